// ===== src/srs_pkg.sv =====
`timescale 1ns / 1ps
package srs_pkg;
   localparam int PAT_W         = 24;
   localparam int BITS_W        = $clog2(PAT_W + 1);
   localparam int BITS_PER_CHIP = 8;
   localparam int MAX_CHIPS_DEF = 3;
   localparam int CC_W          = 2;
   localparam int QDEPTH        = 2;
   localparam int REQ_TDATA_W   = 48;
   localparam int RSP_TDATA_W   = 8;

   localparam logic [CC_W-1:0] CC_RESET = CC_W'(1);

   // one queued job: updated pattern and the number of bits to shift out
   typedef struct packed {
      logic [PAT_W-1:0]  pattern;
      logic [BITS_W-1:0] bits;
   } srs_job_type;

   typedef struct packed {
      logic full;
      logic nonempty;
   } srs_qstat_type;
endpackage

// ===== src/shift_register_serializer.sv =====
`timescale 1ns / 1ps
// Serialiser for a chain of eight-bit shift register chips. Each req beat is a masked
// write to a shadow pattern (mask bits pick which pins take the new level); the
// updated pattern is then sent as chips*8 rsp beats, highest chip byte first, MSB
// first, with tlast on the final bit as the storage latch strobe. The output shifter
// gives one bit per cycle unless rsp_tready stalls it; a queued next write's run
// follows with no gap. Writes are taken one per cycle into a two-deep job queue,
// so the input stalls only when that queue is full.
// The chip count (csr, reset 1, zero acts as one) applies from the next write on.
module shift_register_serializer #(
   parameter int MAX_CHIPS = srs_pkg::MAX_CHIPS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [srs_pkg::CC_W-1:0]         csr_wr_data,   // chip count
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [srs_pkg::REQ_TDATA_W-1:0]  req_tdata,     // write_mask, write_value
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [srs_pkg::RSP_TDATA_W-1:0]  rsp_tdata,     // serial_data, zero pad
   output logic                             rsp_tlast      // latch_pulse
);
   import srs_pkg::*;

   logic          push, pop;
   srs_job_type   push_job, head_job;
   srs_qstat_type qstat;

   srs_front #(.MAX_CHIPS(MAX_CHIPS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .qstat       (qstat),
      .push        (push),
      .push_job    (push_job)
   );

   srs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .qstat    (qstat)
   );

   srs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule

// ===== src/srs_front.sv =====
`timescale 1ns / 1ps
module srs_front #(
   parameter int MAX_CHIPS = srs_pkg::MAX_CHIPS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [srs_pkg::CC_W-1:0]         csr_wr_data,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [srs_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  srs_pkg::srs_qstat_type           qstat,
   output logic                             push,
   output srs_pkg::srs_job_type             push_job
);
   import srs_pkg::*;

   logic [CC_W-1:0]   chain_len_ff, chain_len_in;
   logic [PAT_W-1:0]  shadow_ff, shadow_in;
   logic [2:0]        chips;
   logic [BITS_W-1:0] bits;
   logic [PAT_W:0]    ones_wide;
   logic [PAT_W-1:0]  valid_bits, mask, value, updated;

   always_comb begin
      chips = (chain_len_ff == '0) ? 3'd1 : 3'(chain_len_ff);
      if (int'(chips) > MAX_CHIPS) begin
         chips = 3'(MAX_CHIPS);
      end
   end

   always_comb begin
      bits = BITS_W'(chips) * BITS_W'(BITS_PER_CHIP);
      if (int'(bits) > PAT_W) begin
         bits = BITS_W'(PAT_W);
      end
      ones_wide  = ((PAT_W+1)'(1) << bits) - (PAT_W+1)'(1);
      valid_bits = ones_wide[PAT_W-1:0];
      mask       = req_tdata[PAT_W-1:0] & valid_bits;
      value      = req_tdata[2*PAT_W-1:PAT_W];
      updated    = ((shadow_ff & ~mask) | (value & mask)) & valid_bits;
   end

   assign req_tready       = !qstat.full;
   assign push             = req_tvalid && req_tready;
   assign push_job.pattern = updated;
   assign push_job.bits    = bits;

   assign chain_len_in = csr_wr_en ? csr_wr_data : chain_len_ff;
   assign shadow_in    = push ? updated : shadow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_len_ff <= CC_RESET;
         shadow_ff    <= '0;
      end else begin
         chain_len_ff <= chain_len_in;
         shadow_ff    <= shadow_in;
      end
   end
endmodule

// ===== src/srs_queue.sv =====
`timescale 1ns / 1ps
module srs_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  srs_pkg::srs_job_type   push_job,
   input  logic                   pop,
   output srs_pkg::srs_job_type   head_job,
   output srs_pkg::srs_qstat_type qstat
);
   import srs_pkg::*;

   localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CNT_W = $clog2(QDEPTH + 1);

   srs_job_type      mem [QDEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (int'(p) == QDEPTH - 1) ? '0 : p + PTR_W'(1);
   endfunction

   assign qstat.full     = (int'(count_ff) == QDEPTH);
   assign qstat.nonempty = (count_ff != '0);
   assign head_job       = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

// ===== src/srs_back.sv =====
`timescale 1ns / 1ps
module srs_back (
   input  logic                             clock,
   input  logic                             reset,
   input  srs_pkg::srs_qstat_type           qstat,
   input  srs_pkg::srs_job_type             head_job,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [srs_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);
   import srs_pkg::*;

   logic              active_ff, active_in;
   logic [PAT_W-1:0]  shift_ff, shift_in;
   logic [BITS_W-1:0] remain_ff, remain_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_data_ff, out_data_in;
   logic              out_last_ff, out_last_in;
   logic              out_free, emit, final_bit;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign emit      = active_ff && out_free;
   assign final_bit = (remain_ff == BITS_W'(1));
   // next job loads when idle or in the cycle the final beat is emitted
   assign pop       = qstat.nonempty && (!active_ff || (emit && final_bit));

   always_comb begin
      active_in    = active_ff;
      shift_in     = shift_ff;
      remain_in    = remain_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_data_in  = shift_ff[PAT_W-1];
         out_last_in  = final_bit;
         shift_in     = shift_ff << 1;
         remain_in    = remain_ff - BITS_W'(1);
         if (final_bit) begin
            active_in = 1'b0;
         end
      end
      if (pop) begin
         // top chip's MSB goes to the top of the shifter
         active_in = 1'b1;
         shift_in  = head_job.pattern << (BITS_W'(PAT_W) - head_job.bits);
         remain_in = head_job.bits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      remain_ff   <= remain_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W-1)'(0), out_data_ff};
   assign rsp_tlast  = out_last_ff;
endmodule
